@@ rtl/vmnom_pkg.sv @@
package vmnom_pkg;

    localparam int DimW       = 4;
    localparam int PosW       = 3;
    localparam int LabelW     = 4;
    localparam int DefMaxDim  = 8;
    localparam int MinDim     = 2;
    localparam logic [DimW-1:0] DimReset = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIAG,
        ST_EMIT,
        ST_DRAIN1,
        ST_DRAIN2
    } vmnom_state_t;

    // Travels with each memory read so that it lines up with the read data.
    typedef struct packed {
        logic              diag_we;
        logic              emit_v;
        logic [PosW-1:0]   idx;
        logic [PosW-1:0]   row;
        logic [PosW-1:0]   col;
        logic              run_end;
        logic [DimW-1:0]   dim;
    } vmnom_tag_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] cfg,
                                                  input logic [DimW-1:0] max_dim);
        logic [DimW-1:0] d;
        d = cfg;
        if (cfg < DimW'(MinDim)) d = DimW'(MinDim);
        else if (cfg > max_dim) d = max_dim;
        return d;
    endfunction

endpackage

@@ rtl/vine_matrix_natural_order_max.sv @@
// A load is taken while the block is not busy; an entry outside the triangle
// is dropped. After the request marked last, the block is busy for d reads of
// the anti-diagonal, one entry memory read per result, then DRAIN1 and DRAIN2.
// Results follow the registered memory read and output registers, one per
// cycle; the receiver cannot stall. Reset is asynchronous: the block goes idle
// and the dimension returns to 8; stored entries are not cleared.
module vine_matrix_natural_order_max #(
    parameter int MAX_DIM = vmnom_pkg::DefMaxDim
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vmnom_pkg::DimW-1:0]        cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [vmnom_pkg::PosW-1:0]        row,
    input  logic [vmnom_pkg::PosW-1:0]        col,
    input  logic [vmnom_pkg::LabelW-1:0]      label,
    input  logic                              last,
    output logic                              result_valid,
    output logic [vmnom_pkg::PosW-1:0]        out_row,
    output logic [vmnom_pkg::PosW-1:0]        out_col,
    output logic [vmnom_pkg::LabelW-1:0]      natural_label,
    output logic [vmnom_pkg::LabelW-1:0]      max_label,
    output logic                              need_first_hfunc,
    output logic                              need_second_hfunc,
    output logic                              run_end
);
    import vmnom_pkg::*;

    localparam int AddrW = 2 * $clog2(MAX_DIM);

    logic [DimW-1:0]   vine_dimension_reg;
    logic [DimW-1:0]   cur_dim;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [AddrW-1:0]  rd_addr;
    logic [LabelW-1:0] rd_data;
    vmnom_tag_t        tag;

    assign cfg_ready = 1'b1;
    assign cur_dim   = clamp_dim(vine_dimension_reg, DimW'(MAX_DIM));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vine_dimension_reg <= DimReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vine_dimension_reg <= cfg_data;
        end
    end

    vmnom_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last    (last),
        .row     (row),
        .col     (col),
        .cfg_dim (cur_dim),
        .busy    (busy),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .tag     (tag)
    );

    vmnom_entry_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (label),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vmnom_relabel #(
        .MAX_DIM (MAX_DIM)
    ) u_relabel (
        .clk               (clk),
        .rst_n             (rst_n),
        .tag               (tag),
        .rd_data           (rd_data),
        .result_valid      (result_valid),
        .out_row           (out_row),
        .out_col           (out_col),
        .natural_label     (natural_label),
        .max_label         (max_label),
        .need_first_hfunc  (need_first_hfunc),
        .need_second_hfunc (need_second_hfunc),
        .run_end           (run_end)
    );

endmodule

@@ rtl/vmnom_entry_mem.sv @@
module vmnom_entry_mem #(
    parameter int MAX_DIM = vmnom_pkg::DefMaxDim
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [2*$clog2(MAX_DIM)-1:0]            wr_addr,
    input  logic [vmnom_pkg::LabelW-1:0]            wr_data,
    input  logic [2*$clog2(MAX_DIM)-1:0]            rd_addr,
    output logic [vmnom_pkg::LabelW-1:0]            rd_data
);
    import vmnom_pkg::*;

    localparam int RowW     = $clog2(MAX_DIM);
    localparam int MemDepth = 1 << (2 * RowW);

    logic [LabelW-1:0] mem [MemDepth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/vmnom_ctrl.sv @@
module vmnom_ctrl #(
    parameter int MAX_DIM = vmnom_pkg::DefMaxDim
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                last,
    input  logic [vmnom_pkg::PosW-1:0]          row,
    input  logic [vmnom_pkg::PosW-1:0]          col,
    input  logic [vmnom_pkg::DimW-1:0]          cfg_dim,
    output logic                                busy,
    output logic                                wr_en,
    output logic [2*$clog2(MAX_DIM)-1:0]        wr_addr,
    output logic [2*$clog2(MAX_DIM)-1:0]        rd_addr,
    output vmnom_pkg::vmnom_tag_t               tag
);
    import vmnom_pkg::*;

    localparam int RowW = $clog2(MAX_DIM);

    vmnom_state_t    state_reg, state_next;
    logic [PosW-1:0] cnt_reg, cnt_next;
    logic [PosW-1:0] row_reg, row_next;
    logic [PosW-1:0] col_reg, col_next;
    logic [DimW-1:0] dim_reg, dim_next;
    vmnom_tag_t      tag_reg, tag_next;
    logic            accept;
    logic            diag_done;
    logic            col_end;
    logic            walk_done;
    logic [DimW-1:0] diag_row;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign diag_done = ({1'b0, cnt_reg} == dim_reg - 4'd1);
    assign col_end   = ({1'b0, row_reg} + {1'b0, col_reg} == dim_reg - 4'd1);
    assign walk_done = col_end && ({1'b0, col_reg} == dim_reg - 4'd1);
    assign diag_row  = dim_reg - 4'd1 - {1'b0, cnt_reg};
    assign tag       = tag_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && last) state_next = ST_DIAG;
            ST_DIAG:   if (diag_done) state_next = ST_EMIT;
            ST_EMIT:   if (walk_done) state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and counters.
    always_comb
    begin
        wr_en    = accept && ({1'b0, row} + {1'b0, col} < cfg_dim);
        wr_addr  = {row[RowW-1:0], col[RowW-1:0]};
        rd_addr  = {row_reg[RowW-1:0], col_reg[RowW-1:0]};
        cnt_next = '0;
        row_next = row_reg;
        col_next = col_reg;
        dim_next = dim_reg;
        tag_next = '0;
        tag_next.dim = dim_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                row_next = '0;
                col_next = '0;
                if (accept && last) dim_next = cfg_dim;
            end
            ST_DIAG:
            begin
                rd_addr          = {diag_row[RowW-1:0], cnt_reg[RowW-1:0]};
                cnt_next         = cnt_reg + 3'd1;
                tag_next.diag_we = 1'b1;
                tag_next.idx     = cnt_reg;
            end
            ST_EMIT:
            begin
                tag_next.emit_v  = 1'b1;
                tag_next.row     = row_reg;
                tag_next.col     = col_reg;
                tag_next.run_end = walk_done;
                if (col_end)
                begin
                    row_next = '0;
                    col_next = col_reg + 3'd1;
                end
                else
                begin
                    row_next = row_reg + 3'd1;
                end
            end
            ST_DRAIN1, ST_DRAIN2:
            begin
                row_next = '0;
                col_next = '0;
            end
            default:
            begin
                row_next = '0;
                col_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            dim_reg   <= DimReset;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            dim_reg   <= dim_next;
            tag_reg   <= tag_next;
        end
    end

`ifndef SYNTH
    a_tag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.emit_v |-> !tag_reg.diag_we)
        else $error("diag capture and emit tag at once");

    a_tag_in_tri: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.emit_v |-> ({1'b0, tag_reg.row} + {1'b0, tag_reg.col} < tag_reg.dim))
        else $error("emitted position outside the triangle");

    a_end_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_reg.emit_v && tag_reg.run_end) |-> (state_reg == ST_DRAIN1))
        else $error("final entry tag out of step with the sequencer");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && last))
        else $error("run started without a last request");
`endif

endmodule

@@ rtl/vmnom_relabel.sv @@
module vmnom_relabel #(
    parameter int MAX_DIM = vmnom_pkg::DefMaxDim
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vmnom_pkg::vmnom_tag_t             tag,
    input  logic [vmnom_pkg::LabelW-1:0]      rd_data,
    output logic                              result_valid,
    output logic [vmnom_pkg::PosW-1:0]        out_row,
    output logic [vmnom_pkg::PosW-1:0]        out_col,
    output logic [vmnom_pkg::LabelW-1:0]      natural_label,
    output logic [vmnom_pkg::LabelW-1:0]      max_label,
    output logic                              need_first_hfunc,
    output logic                              need_second_hfunc,
    output logic                              run_end
);
    import vmnom_pkg::*;

    localparam int RowW = $clog2(MAX_DIM);
    localparam int LabW = $clog2(MAX_DIM + 1);

    logic [LabelW-1:0] diag_reg [MAX_DIM];
    // Per row and per max value: some earlier column had that max with a
    // natural label that differs from it (ne) or equals it (eq).
    logic [MAX_DIM:0]  ne_reg [MAX_DIM];
    logic [MAX_DIM:0]  eq_reg [MAX_DIM];
    logic [LabelW-1:0] max_run_reg;
    logic              valid_reg;

    logic [LabelW-1:0] nat;
    logic [LabelW-1:0] max_val;
    logic [DimW-1:0]   j;
    logic [RowW-1:0]   r_i;
    logic              first_f;
    logic              second_f;

    assign r_i = tag.row[RowW-1:0];
    assign j   = tag.dim - {1'b0, tag.col};

    // The smallest matching anti-diagonal column wins, so scan downward.
    always_comb
    begin
        nat = '0;
        for (int k = MAX_DIM - 1; k >= 0; k--)
        begin
            if ((DimW'(k) < tag.dim) && (diag_reg[k] == rd_data))
            begin
                nat = tag.dim - DimW'(k);
            end
        end
    end

    always_comb
    begin
        max_val = nat;
        if ((tag.row != '0) && (max_run_reg > nat)) max_val = max_run_reg;
    end

    always_comb
    begin
        first_f  = (tag.col != '0) && ({1'b0, tag.col} + 4'd2 <= tag.dim)
                   && ne_reg[r_i][j[LabW-1:0]];
        second_f = 1'b0;
        if (tag.col == '0)
        begin
            second_f = ({1'b0, tag.row} + 4'd2 <= tag.dim);
        end
        else if ({1'b0, tag.col} + 4'd2 <= tag.dim)
        begin
            if ({1'b0, tag.row} + 4'd1 < j) second_f = 1'b1;
            else second_f = eq_reg[r_i][j[LabW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag.diag_we)
        begin
            diag_reg[tag.idx[RowW-1:0]] <= rd_data;
            for (int r = 0; r < MAX_DIM; r++)
            begin
                ne_reg[r] <= '0;
                eq_reg[r] <= '0;
            end
        end
        if (tag.emit_v)
        begin
            max_run_reg <= max_val;
            if (nat != max_val) ne_reg[r_i][max_val[LabW-1:0]] <= 1'b1;
            else eq_reg[r_i][max_val[LabW-1:0]] <= 1'b1;
            out_row           <= tag.row;
            out_col           <= tag.col;
            natural_label     <= nat;
            max_label         <= max_val;
            need_first_hfunc  <= first_f;
            need_second_hfunc <= second_f;
            run_end           <= tag.run_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag.emit_v;
        end
    end

    assign result_valid = valid_reg;

endmodule

@@ sim/vine_matrix_natural_order_max_tb.sv @@
`timescale 1ns / 100ps

module vine_matrix_natural_order_max_tb;

    localparam int TreeMax = 8;
    localparam int CycleLimit = 400000;
    localparam int LoadTarget = 350;
    // Outlasts the busy period after the last request.
    localparam int TailCycles = 60;

    typedef struct packed {
        logic [2:0] pos_row;
        logic [2:0] pos_col;
        logic [3:0] nat;
        logic [3:0] peak;
        logic       hf1;
        logic       hf2;
        logic       fin;
    } vine_result_t;

    typedef struct {
        bit         set_dim;
        logic [3:0] dim_val;
        logic [2:0] r;
        logic [2:0] c;
        logic [3:0] lb;
        logic       lst;
        bit         typed;
    } load_step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [vmnom_pkg::DimW-1:0] cfg_data;
    logic start;
    logic busy;
    logic [vmnom_pkg::PosW-1:0] row;
    logic [vmnom_pkg::PosW-1:0] col;
    logic [vmnom_pkg::LabelW-1:0] label;
    logic last;
    logic result_valid;
    logic [vmnom_pkg::PosW-1:0] out_row;
    logic [vmnom_pkg::PosW-1:0] out_col;
    logic [vmnom_pkg::LabelW-1:0] natural_label;
    logic [vmnom_pkg::LabelW-1:0] max_label;
    logic need_first_hfunc;
    logic need_second_hfunc;
    logic run_end;

    vine_matrix_natural_order_max #(.MAX_DIM(TreeMax)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .row(row),
        .col(col),
        .label(label),
        .last(last),
        .result_valid(result_valid),
        .out_row(out_row),
        .out_col(out_col),
        .natural_label(natural_label),
        .max_label(max_label),
        .need_first_hfunc(need_first_hfunc),
        .need_second_hfunc(need_second_hfunc),
        .run_end(run_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block's triangle stores and dimension register.
    logic [3:0] entry_mem [TreeMax][TreeMax];
    logic [3:0] natural_mem [TreeMax][TreeMax];
    logic [3:0] max_mem [TreeMax][TreeMax];
    logic [3:0] dim_reg;

    vine_result_t run_results[$];
    vine_result_t expected_entries[$];
    vine_result_t typed_results[$];
    vine_result_t want;

    int fail_count = 0;
    int cycle_count = 0;
    int load_count = 0;
    bit quiet = 1'b0;

    function automatic int eff_dim();
        if (dim_reg < 4'd2)
            return 2;
        if (dim_reg > 4'(TreeMax))
            return TreeMax;
        return int'(dim_reg);
    endfunction

    function automatic bit need_first(int r, int c, int d);
        int j;
        bit hit;
        if (c < 1 || c + 2 > d)
            return 1'b0;
        j = d - c;
        hit = 1'b0;
        for (int k = 0; k < c; k++)
            if (int'(natural_mem[r][k]) != j && int'(max_mem[r][k]) == j)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic bit need_second(int r, int c, int d);
        int j;
        bit hit;
        if (c == 0)
            return (r + 2 <= d);
        if (c + 2 > d)
            return 1'b0;
        j = d - c;
        if (r + 1 < j)
            return 1'b1;
        hit = 1'b0;
        for (int k = 0; k < c; k++)
            if (int'(natural_mem[r][k]) == j && int'(max_mem[r][k]) == j)
                hit = 1'b1;
        return hit;
    endfunction

    // Stores the entry, and on the final request relabels the triangle to natural
    // order, takes the column maxima and lists the entries in emission order.
    task automatic relabel_triangle(input logic [2:0] r, input logic [2:0] c,
                                    input logic [3:0] lb, input logic lst);
        int d;
        bit hit;
        logic [3:0] nl;
        logic [3:0] m;
        vine_result_t res;
        d = eff_dim();
        run_results.delete();
        if (int'(r) + int'(c) < d)
            entry_mem[r][c] = lb;
        if (lst)
        begin
            for (int cc = 0; cc < d; cc++)
                for (int rr = 0; rr + cc < d; rr++)
                begin
                    nl = 4'd0;
                    hit = 1'b0;
                    for (int k = 0; k < d; k++)
                        if (!hit && entry_mem[d - 1 - k][k] == entry_mem[rr][cc])
                        begin
                            nl = 4'(d - k);
                            hit = 1'b1;
                        end
                    natural_mem[rr][cc] = nl;
                end
            for (int cc = 0; cc < d; cc++)
                for (int rr = 0; rr + cc < d; rr++)
                begin
                    m = natural_mem[rr][cc];
                    if (rr > 0 && max_mem[rr - 1][cc] > m)
                        m = max_mem[rr - 1][cc];
                    max_mem[rr][cc] = m;
                end
            for (int cc = 0; cc < d; cc++)
                for (int rr = 0; rr + cc < d; rr++)
                begin
                    res.pos_row = 3'(rr);
                    res.pos_col = 3'(cc);
                    res.nat = natural_mem[rr][cc];
                    res.peak = max_mem[rr][cc];
                    res.hf1 = need_first(rr, cc, d);
                    res.hf2 = need_second(rr, cc, d);
                    res.fin = (cc + 1 == d);
                    run_results.push_back(res);
                end
        end
    endtask

    // Presents one request from a falling edge and holds it until busy is low
    // at a rising edge. Returns at the following falling edge.
    task automatic send_req(input logic [2:0] r, input logic [2:0] c,
                            input logic [3:0] lb, input logic lst, input bit typed);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        row = r;
        col = c;
        label = lb;
        last = lst;
        load_count++;
        do
            @(posedge clk);
        while (busy);
        relabel_triangle(r, c, lb, lst);
        if (typed)
            foreach (typed_results[i])
                expected_entries.push_back(typed_results[i]);
        else
            foreach (run_results[i])
                expected_entries.push_back(run_results[i]);
        @(negedge clk);
    endtask

    task automatic write_dim(input logic [3:0] v);
        start = 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        // The bench idles between the finished run and the register write.
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        dim_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_entries.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual row %0d col %0d",
                         $time, out_row, out_col);
                fail_count++;
            end
            else
            begin
                want = expected_entries.pop_front();
                check_field("out_row", int'(want.pos_row), int'(out_row));
                check_field("out_col", int'(want.pos_col), int'(out_col));
                check_field("natural_label", int'(want.nat), int'(natural_label));
                check_field("max_label", int'(want.peak), int'(max_label));
                check_field("need_first_hfunc", int'(want.hf1), int'(need_first_hfunc));
                check_field("need_second_hfunc", int'(want.hf2),
                            int'(need_second_hfunc));
                check_field("run_end", int'(want.fin), int'(run_end));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic load_step_t plan_step(int set_dim, int dim_val, int r, int c,
                                             int lb, int lst, int typed);
        load_step_t s;
        s.set_dim = set_dim[0];
        s.dim_val = 4'(dim_val);
        s.r = 3'(r);
        s.c = 3'(c);
        s.lb = 4'(lb);
        s.lst = lst[0];
        s.typed = typed[0];
        return s;
    endfunction

    function automatic vine_result_t known_result(int r, int c, int nat, int peak,
                                                  int hf1, int hf2, int fin);
        vine_result_t res;
        res.pos_row = 3'(r);
        res.pos_col = 3'(c);
        res.nat = 4'(nat);
        res.peak = 4'(peak);
        res.hf1 = hf1[0];
        res.hf2 = hf2[0];
        res.fin = fin[0];
        return res;
    endfunction

    initial
    begin : stimulus
        load_step_t plan[$];
        int d;
        int n;
        int t;
        int lo;
        int rr;
        int cc;
        int diag_lab [TreeMax];
        int pos_r [36];
        int pos_c [36];
        int run_no;
        logic [3:0] v;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        row = '0;
        col = '0;
        label = '0;
        last = 1'b0;
        dim_reg = vmnom_pkg::DimReset;

        // Dimension 0 acts as 2. Labels equal to an anti-diagonal entry get d-k.
        plan.push_back(plan_step(1, 0, 0, 0, 2, 0, 0));
        plan.push_back(plan_step(0, 0, 1, 0, 1, 0, 0));
        plan.push_back(plan_step(0, 0, 7, 7, 15, 0, 0));
        plan.push_back(plan_step(0, 0, 0, 1, 2, 1, 1));
        // Dimension 1 acts as 2; a final request outside the triangle still runs.
        plan.push_back(plan_step(1, 1, 1, 1, 0, 1, 0));
        // Labels above d and zero, and a repeated anti-diagonal label.
        plan.push_back(plan_step(1, 3, 0, 0, 9, 0, 0));
        plan.push_back(plan_step(0, 0, 1, 0, 0, 0, 0));
        plan.push_back(plan_step(0, 0, 2, 0, 5, 0, 0));
        plan.push_back(plan_step(0, 0, 0, 1, 5, 0, 0));
        plan.push_back(plan_step(0, 0, 1, 1, 5, 0, 0));
        plan.push_back(plan_step(0, 0, 0, 2, 2, 1, 0));
        // Grow to 4, reusing entries loaded at dimension 3.
        plan.push_back(plan_step(1, 4, 3, 0, 1, 0, 0));
        plan.push_back(plan_step(0, 0, 2, 1, 2, 0, 0));
        plan.push_back(plan_step(0, 0, 3, 4, 6, 0, 0));
        plan.push_back(plan_step(0, 0, 1, 2, 3, 0, 0));
        plan.push_back(plan_step(0, 0, 0, 3, 4, 1, 0));

        typed_results.push_back(known_result(0, 0, 1, 1, 0, 1, 0));
        typed_results.push_back(known_result(1, 0, 2, 2, 0, 0, 0));
        typed_results.push_back(known_result(0, 1, 1, 1, 0, 0, 1));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_dim)
                write_dim(plan[i].dim_val);
            quiet = ($urandom_range(0, 2) == 0);
            send_req(plan[i].r, plan[i].c, plan[i].lb, plan[i].lst, plan[i].typed);
        end

        // The first random run loads the whole largest triangle, so every later
        // run only reads entries that have been written.
        run_no = 0;
        while (load_count < LoadTarget)
        begin
            if (run_no == 0)
                write_dim(4'd15);
            else if (run_no == 1)
                write_dim(4'd8);
            else if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    v = 4'($urandom_range(0, 15));
                else
                    v = 4'($urandom_range(2, 8));
                write_dim(v);
            end
            d = eff_dim();
            quiet = ($urandom_range(0, 3) == 0);

            if (run_no < 2 || $urandom_range(0, 3) != 0)
            begin
                // Well-formed structure: the anti-diagonal holds each label once,
                // and entries above it come from anti-diagonals further right, with an occasional random label.
                for (int k = 0; k < d; k++)
                    diag_lab[k] = k + 1;
                for (int k = d - 1; k > 0; k--)
                begin
                    t = $urandom_range(0, k);
                    lo = diag_lab[k];
                    diag_lab[k] = diag_lab[t];
                    diag_lab[t] = lo;
                end
                n = 0;
                for (int c = 0; c < d; c++)
                    for (int r = 0; r + c < d; r++)
                    begin
                        pos_r[n] = r;
                        pos_c[n] = c;
                        n++;
                    end
                for (int k = n - 1; k > 0; k--)
                begin
                    t = $urandom_range(0, k);
                    rr = pos_r[k];
                    cc = pos_c[k];
                    pos_r[k] = pos_r[t];
                    pos_c[k] = pos_c[t];
                    pos_r[t] = rr;
                    pos_c[t] = cc;
                end
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        rr = $urandom_range(0, 7);
                        lo = d - rr;
                        if (lo < 0)
                            lo = 0;
                        if (lo > 7)
                        begin
                            rr = 7;
                            lo = d - 7;
                        end
                        send_req(3'(rr), 3'($urandom_range(lo, 7)),
                                 4'($urandom_range(0, 15)), 1'b0, 1'b0);
                    end
                    rr = pos_r[k];
                    cc = pos_c[k];
                    if (rr + cc == d - 1)
                        v = 4'(diag_lab[cc]);
                    else if ($urandom_range(0, 6) == 0)
                        v = 4'($urandom_range(0, 15));
                    else
                        v = 4'(diag_lab[$urandom_range(cc + 1, d - 1)]);
                    send_req(3'(rr), 3'(cc), v, k == n - 1, 1'b0);
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                             4'($urandom_range(0, 15)), 1'b0, 1'b0);
                send_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)), 1'b1, 1'b0);
            end
            run_no++;
        end

        start = 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
